// ----- src/i2cbb_pkg.sv -----
// Shared types and codes for the I2C bit-bang master.
// No dependencies; every other file imports this package.
package i2cbb_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned BCNT_W  = 4;

  // Command / mode codes
  localparam logic [MODE_W-1:0] CMD_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] CMD_START = 3'd1;
  localparam logic [MODE_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [MODE_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [MODE_W-1:0] CMD_READ  = 3'd4;

  // Data bits per byte, as a bit counter value
  localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic              sda_sample;
  } tick_t;

  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              nack_error;
    logic              cmd_error;
  } res_t;

endpackage

// ----- src/i2cbb_if.sv -----
// Handshake channels of the I2C bit-bang master: tick items in, result items out.
// Depends on i2cbb_pkg for field widths.
interface i2cbb_tick_if import i2cbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  logic              sda_sample;

  modport source (output valid, mode, data_byte, last_byte, sda_sample, input ready);
  modport sink   (input valid, mode, data_byte, last_byte, sda_sample, output ready);
endinterface

interface i2cbb_res_if import i2cbb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              sda_drive;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              nack_error;
  logic              cmd_error;

  modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, nack_error, cmd_error, input ready);
  modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                  rx_byte, nack_error, cmd_error, output ready);
endinterface

// ----- src/i2cbb_seq.sv -----
// Bus phase sequencer: state registers and the one-slot next-state logic.
// Depends on i2cbb_pkg.
module i2cbb_seq import i2cbb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  tick_t tick_in,
  input  logic  lsb_first,
  output res_t  res_d
);

  logic [MODE_W-1:0]  active_cmd, active_cmd_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [BCNT_W-1:0]  bit_count, bit_count_next;
  logic [BYTE_W-1:0]  shift_byte, shift_byte_next;
  logic               nack_last, nack_last_next;
  logic               scl_reg, scl_reg_next;
  logic               sda_reg, sda_reg_next;
  logic               sda_oe_reg, sda_oe_reg_next;

  logic              is_cmd;
  logic              cmd_err;
  logic              done;
  logic              is_start;
  logic              wr;
  logic [MODE_W-1:0] finished;

  always_comb begin
    active_cmd_next = active_cmd;
    phase_next      = phase;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    nack_last_next  = nack_last;
    scl_reg_next    = scl_reg;
    sda_reg_next    = sda_reg;
    sda_oe_reg_next = sda_oe_reg;
    cmd_err         = 1'b0;
    done            = 1'b0;
    finished        = CMD_IDLE;

    is_cmd = (tick_in.mode inside {[CMD_START:CMD_READ]});

    // Take a new command only while idle
    if (is_cmd) begin
      if (active_cmd != CMD_IDLE) begin
        cmd_err = 1'b1;
      end else begin
        active_cmd_next = tick_in.mode;
        phase_next      = '0;
        bit_count_next  = '0;
        shift_byte_next = (tick_in.mode == CMD_WRITE) ? tick_in.data_byte : '0;
        nack_last_next  = (tick_in.mode == CMD_READ) ? tick_in.last_byte : 1'b0;
      end
    end

    is_start = (active_cmd_next == CMD_START);
    wr       = (active_cmd_next == CMD_WRITE);

    case (active_cmd_next)
      CMD_IDLE: begin
      end
      CMD_START, CMD_STOP: begin
        case (phase_next)
          2'd0: begin
            scl_reg_next    = is_start;
            sda_oe_reg_next = 1'b1;
            phase_next      = phase_next + 1'b1;
          end
          2'd1: begin
            sda_reg_next = is_start;
            phase_next   = phase_next + 1'b1;
          end
          2'd2: begin
            if (is_start) sda_reg_next = 1'b0;
            else          scl_reg_next = 1'b1;
            phase_next = phase_next + 1'b1;
          end
          default: begin
            if (is_start) scl_reg_next = 1'b0;
            else          sda_reg_next = 1'b1;
            done = 1'b1;
          end
        endcase
      end
      CMD_WRITE, CMD_READ: begin
        if (bit_count_next < BITS_PER_BYTE) begin
          case (phase_next)
            2'd0: begin
              scl_reg_next = 1'b0;
              if (wr) begin
                sda_oe_reg_next = 1'b1;
                if (lsb_first) begin
                  sda_reg_next    = shift_byte_next[0];
                  shift_byte_next = {1'b0, shift_byte_next[BYTE_W-1:1]};
                end else begin
                  sda_reg_next    = shift_byte_next[BYTE_W-1];
                  shift_byte_next = {shift_byte_next[BYTE_W-2:0], 1'b0};
                end
              end else begin
                sda_oe_reg_next = 1'b0;
              end
              phase_next = phase_next + 1'b1;
            end
            2'd1: begin
              scl_reg_next = 1'b1;
              if (!wr) begin
                if (lsb_first)
                  shift_byte_next = {tick_in.sda_sample, shift_byte_next[BYTE_W-1:1]};
                else
                  shift_byte_next = {shift_byte_next[BYTE_W-2:0], tick_in.sda_sample};
              end
              phase_next = phase_next + 1'b1;
            end
            default: begin
              scl_reg_next   = 1'b0;
              phase_next     = '0;
              bit_count_next = bit_count_next + 1'b1;
            end
          endcase
        end else begin
          // Acknowledge bit
          case (phase_next)
            2'd0: begin
              scl_reg_next = 1'b0;
              if (wr) begin
                sda_oe_reg_next = 1'b0;
              end else begin
                sda_reg_next    = nack_last_next;
                sda_oe_reg_next = 1'b1;
              end
              phase_next = phase_next + 1'b1;
            end
            2'd1: begin
              scl_reg_next = 1'b1;
              if (wr) nack_last_next = tick_in.sda_sample;
              phase_next = phase_next + 1'b1;
            end
            default: begin
              scl_reg_next    = 1'b0;
              sda_reg_next    = 1'b0;
              sda_oe_reg_next = 1'b1;
              done            = 1'b1;
            end
          endcase
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (done) begin
      finished        = active_cmd_next;
      active_cmd_next = CMD_IDLE;
      phase_next      = '0;
      bit_count_next  = '0;
    end

    res_d.scl_level  = scl_reg_next;
    res_d.sda_level  = sda_reg_next;
    res_d.sda_drive  = sda_oe_reg_next;
    res_d.busy_res   = (active_cmd_next != CMD_IDLE);
    res_d.done_res   = done;
    res_d.rx_byte    = (finished == CMD_READ) ? shift_byte_next : '0;
    res_d.nack_error = (finished == CMD_WRITE) ? nack_last_next : 1'b0;
    res_d.cmd_error  = cmd_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cmd <= CMD_IDLE;
      phase      <= '0;
      bit_count  <= '0;
      shift_byte <= '0;
      nack_last  <= 1'b0;
      scl_reg    <= 1'b1;
      sda_reg    <= 1'b1;
      sda_oe_reg <= 1'b1;
    end else if (accept) begin
      active_cmd <= active_cmd_next;
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      nack_last  <= nack_last_next;
      scl_reg    <= scl_reg_next;
      sda_reg    <= sda_reg_next;
      sda_oe_reg <= sda_oe_reg_next;
    end
  end

`ifndef SYNTHESIS
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BITS_PER_BYTE)
    else $error("bit counter past one byte");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (active_cmd == CMD_IDLE) |-> (phase == '0 && bit_count == '0))
    else $error("idle sequencer holds stale phase or bit count");

  a_byte_phase: assert property (@(posedge clk) disable iff (rst)
    (active_cmd == CMD_WRITE || active_cmd == CMD_READ) |-> (phase <= 2'd2))
    else $error("byte transfer phase out of range");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && active_cmd == CMD_IDLE && !is_cmd) |=>
      ($stable(scl_reg) && $stable(sda_reg) && $stable(sda_oe_reg)))
    else $error("pins moved on an idle tick");
`endif

endmodule

// ----- src/i2cbb_out_reg.sv -----
// Result register between the sequencer and the output channel.
// Depends on i2cbb_pkg.
module i2cbb_out_reg import i2cbb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t d,
  input  logic out_ready,
  output logic out_valid,
  output logic can_load,
  output res_t q
);

  // Free when empty or drained in this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

// ----- src/i2c_bitbang_master.sv -----
// Top level of the I2C bit-bang master: config register, sequencer, result register.
// Depends on i2cbb_pkg, i2cbb_if, i2cbb_seq, i2cbb_out_reg.
//
//   port       kind        role                 fields
//   tick       sink        one bus delay slot   mode, data_byte, last_byte, sda_sample
//   res        source      pin levels, status   scl_level .. cmd_error
//   cfg_we     write       bit order register   cfg_wdata -> lsb_first
//
// Every tick item yields exactly one result item; one item per cycle is sustained while res.ready stays high.
// The sequencer's next-state logic feeds the result register, which holds the result the cycle after its tick is taken.
// Reset leaves the bus released (SCL and SDA high, SDA driven) and the sequencer idle.
// A stalled result holds in the register; tick.ready drops only while it is still full.
module i2c_bitbang_master import i2cbb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  i2cbb_tick_if.sink    tick,
  i2cbb_res_if.source   res,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  logic  lsb_first;
  logic  accept;
  logic  can_load;
  tick_t tick_in;
  res_t  res_d;
  res_t  res_q;

  // Bit order register, to be written only while the block is quiet; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_first <= 1'b0;
    end else if (cfg_we) begin
      lsb_first <= cfg_wdata;
    end
  end

  // Accept a tick whenever the result slot is free or draining
  assign tick.ready = can_load;
  assign accept     = tick.valid && can_load;

  assign tick_in.mode       = tick.mode;
  assign tick_in.data_byte  = tick.data_byte;
  assign tick_in.last_byte  = tick.last_byte;
  assign tick_in.sda_sample = tick.sda_sample;

  // Advance the bus sequence by one slot per accepted tick
  i2cbb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .tick_in   (tick_in),
    .lsb_first (lsb_first),
    .res_d     (res_d)
  );

  // Hold the result until the sink takes it
  i2cbb_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .d         (res_d),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .can_load  (can_load),
    .q         (res_q)
  );

  assign res.scl_level  = res_q.scl_level;
  assign res.sda_level  = res_q.sda_level;
  assign res.sda_drive  = res_q.sda_drive;
  assign res.busy_res   = res_q.busy_res;
  assign res.done_res   = res_q.done_res;
  assign res.rx_byte    = res_q.rx_byte;
  assign res.nack_error = res_q.nack_error;
  assign res.cmd_error  = res_q.cmd_error;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.done_res) |-> !res.busy_res)
    else $error("result reports done while still busy");

  a_rx_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.done_res) |-> (res.rx_byte == '0 && !res.nack_error))
    else $error("read data or nack flagged without done");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !tick.ready)
    else $error("tick taken while result stalled");
`endif

endmodule
